// ----- hdl/pfx_eval_pkg.sv -----
// ----------------------------------------------------------------------------
// pfx_eval_pkg
// Shared types and character codes for the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pfx_eval_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = 5;   // counts the bits of one word

    // character codes
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_STAR  = 8'd42;
    localparam logic [7:0] CH_SLASH = 8'd47;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNDER   = 2'd1;
    localparam logic [1:0] ST_DIVZERO = 2'd2;
    localparam logic [1:0] ST_OVER    = 2'd3;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_READ_R = 9'b000000010,
        S_READ_L = 9'b000000100,
        S_LOAD   = 9'b000001000,
        S_CALC   = 9'b000010000,
        S_WRITE  = 9'b000100000,
        S_FINISH = 9'b001000000,
        S_EMIT   = 9'b010000000,
        S_SPARE  = 9'b100000000
    } state_t;

endpackage

// ----- hdl/postfix_expression_evaluator.sv -----
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Evaluates a postfix expression streamed one character per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one character per transfer, s_tdata[7:0] = symbol, s_tlast
//   marks the final character of an expression. Digits (any character other
//   than + - * /) push their code minus 48; operators pop two operands and
//   push the result of 32-bit wrapping arithmetic, divide truncating to zero.
//   Master channel: one transfer per expression, after the character marked
//   last: m_tdata[31:0] = value (top of stack), m_tdata[33:32] = status.
// Sequence:
//   An operand or an underflowing operator takes the transfer and a finish
//   step. A complete operator takes the transfer, two stack memory reads, a
//   load step, the bit-serial add/subtract, shift-add multiply or restoring
//   divide over every bit of the word, one write back and one finish step.
//   A divide by zero skips the bit-serial step. A last item adds an emit
//   step to move the top of stack into the output register.
// Reset and stall:
//   aresetn (synchronous, active low) empties the stack and clears the error;
//   the stack memory itself is not cleared. While the output register holds
//   an untaken result the block still takes characters; the next result
//   waits in the emit step until the output register is free.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] symbol
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [31:0] value, [33:32] status, [39:34] zero
);

    localparam int W  = pfx_eval_pkg::WORD_W;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNW = pfx_eval_pkg::CNT_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    pfx_eval_pkg::state_t state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [1:0]     err_reg, err_next;
    logic           last_reg, last_next;
    pfx_eval_pkg::op_t op_reg, op_next;
    logic [W-1:0]   a_reg, a_next;        // lhs / dividend, then quotient
    logic [W-1:0]   b_reg, b_next;        // rhs / divisor
    logic [W-1:0]   acc_reg, acc_next;    // sum, product or remainder
    logic           carry_reg, carry_next;
    logic           neg_reg, neg_next;
    logic [CNW-1:0] bit_reg, bit_next;
    logic           mvalid_reg, mvalid_next;
    logic [W-1:0]   mvalue_reg, mvalue_next;
    logic [1:0]     mstatus_reg, mstatus_next;

    // stack memory, registered read
    logic [W-1:0]   stack_mem [STACK_DEPTH];
    logic [W-1:0]   rd_data_reg;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    logic [W-1:0]   wr_data;
    logic           wr_en;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    logic           s_xfer;
    logic           out_free;
    logic           is_op;
    logic [CW-1:0]  count_m1;
    logic [CW-1:0]  count_m2;
    logic [W-1:0]   operand_val;
    logic [W-1:0]   lhs_abs;
    logic [W-1:0]   rhs_abs;
    logic           add_b;
    logic           add_s;
    logic           add_c;
    logic [W:0]     rem_sh;
    logic [W:0]     rem_diff;
    logic [W-1:0]   result;

    assign s_tready = (state_reg == pfx_eval_pkg::S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;

    assign is_op = (s_tdata == pfx_eval_pkg::CH_PLUS)  || (s_tdata == pfx_eval_pkg::CH_MINUS) ||
                   (s_tdata == pfx_eval_pkg::CH_STAR)  || (s_tdata == pfx_eval_pkg::CH_SLASH);

    assign count_m1    = count_reg - CW'(1);
    assign count_m2    = count_reg - CW'(2);
    assign operand_val = {{(W-8){1'b0}}, s_tdata} - {{(W-8){1'b0}}, pfx_eval_pkg::CH_ZERO};

    // operand magnitudes for the divide
    assign lhs_abs = rd_data_reg[W-1] ? (W'(0) - rd_data_reg) : rd_data_reg;
    assign rhs_abs = b_reg[W-1] ? (W'(0) - b_reg) : b_reg;

    // one bit of the serial adder; subtract adds the inverted rhs plus one
    assign add_b = b_reg[0] ^ (op_reg == pfx_eval_pkg::OP_SUB);
    assign add_s = a_reg[0] ^ add_b ^ carry_reg;
    assign add_c = (a_reg[0] & add_b) | (carry_reg & (a_reg[0] ^ add_b));

    // one step of the restoring divide
    assign rem_sh   = {acc_reg, a_reg[W-1]};
    assign rem_diff = rem_sh - {1'b0, b_reg};

    // value written back after the operator
    always_comb begin
        case (op_reg)
            pfx_eval_pkg::OP_DIV: result = neg_reg ? (W'(0) - a_reg) : a_reg;
            default:              result = acc_reg;
        endcase
    end

    // memory port control: read the rhs first, then the lhs
    assign rd_addr = (state_reg == pfx_eval_pkg::S_READ_L) ? count_m2[AW-1:0]
                                                           : count_m1[AW-1:0];
    assign wr_addr = (state_reg == pfx_eval_pkg::S_WRITE) ? count_m2[AW-1:0]
                                                          : count_reg[AW-1:0];
    assign wr_data = (state_reg == pfx_eval_pkg::S_WRITE) ? result : operand_val;
    assign wr_en   = (state_reg == pfx_eval_pkg::S_WRITE) ||
                     (s_xfer && !is_op && (count_reg < CW'(STACK_DEPTH)));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        err_next     = err_reg;
        last_next    = last_reg;
        op_next      = op_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        acc_next     = acc_reg;
        carry_next   = carry_reg;
        neg_next     = neg_reg;
        bit_next     = bit_reg;
        mvalid_next  = mvalid_reg && !m_tready;
        mvalue_next  = mvalue_reg;
        mstatus_next = mstatus_reg;

        case (state_reg)
            pfx_eval_pkg::S_IDLE: begin
                if (s_xfer) begin
                    last_next  = s_tlast;
                    state_next = pfx_eval_pkg::S_FINISH;
                    case (s_tdata)
                        pfx_eval_pkg::CH_PLUS:  op_next = pfx_eval_pkg::OP_ADD;
                        pfx_eval_pkg::CH_MINUS: op_next = pfx_eval_pkg::OP_SUB;
                        pfx_eval_pkg::CH_STAR:  op_next = pfx_eval_pkg::OP_MUL;
                        default:                op_next = pfx_eval_pkg::OP_DIV;
                    endcase
                    if (is_op) begin
                        if (count_reg < CW'(2)) begin
                            // underflow: leave the stack as it is
                            if (err_reg == pfx_eval_pkg::ST_OK) begin
                                err_next = pfx_eval_pkg::ST_UNDER;
                            end
                        end else begin
                            state_next = pfx_eval_pkg::S_READ_R;
                        end
                    end else if (count_reg < CW'(STACK_DEPTH)) begin
                        count_next = count_reg + CW'(1);
                    end else if (err_reg == pfx_eval_pkg::ST_OK) begin
                        // full stack: drop the operand
                        err_next = pfx_eval_pkg::ST_OVER;
                    end
                end
            end
            pfx_eval_pkg::S_READ_R: begin
                state_next = pfx_eval_pkg::S_READ_L;
            end
            pfx_eval_pkg::S_READ_L: begin
                b_next     = rd_data_reg;
                state_next = pfx_eval_pkg::S_LOAD;
            end
            pfx_eval_pkg::S_LOAD: begin
                a_next     = rd_data_reg;
                acc_next   = '0;
                carry_next = (op_reg == pfx_eval_pkg::OP_SUB);
                neg_next   = 1'b0;
                bit_next   = '0;
                state_next = pfx_eval_pkg::S_CALC;
                if (op_reg == pfx_eval_pkg::OP_DIV) begin
                    if (b_reg == '0) begin
                        // divide by zero pushes zero
                        a_next     = '0;
                        state_next = pfx_eval_pkg::S_WRITE;
                        if (err_reg == pfx_eval_pkg::ST_OK) begin
                            err_next = pfx_eval_pkg::ST_DIVZERO;
                        end
                    end else begin
                        a_next   = lhs_abs;
                        b_next   = rhs_abs;
                        neg_next = rd_data_reg[W-1] ^ b_reg[W-1];
                    end
                end
            end
            pfx_eval_pkg::S_CALC: begin
                bit_next = bit_reg + CNW'(1);
                case (op_reg)
                    pfx_eval_pkg::OP_MUL: begin
                        if (b_reg[0]) begin
                            acc_next = acc_reg + a_reg;
                        end
                        a_next = {a_reg[W-2:0], 1'b0};
                        b_next = {1'b0, b_reg[W-1:1]};
                    end
                    pfx_eval_pkg::OP_DIV: begin
                        if (!rem_diff[W]) begin
                            acc_next = rem_diff[W-1:0];
                        end else begin
                            acc_next = rem_sh[W-1:0];
                        end
                        a_next = {a_reg[W-2:0], !rem_diff[W]};
                    end
                    default: begin
                        // shift the sum in from the top, LSB first
                        acc_next   = {add_s, acc_reg[W-1:1]};
                        carry_next = add_c;
                        a_next     = {1'b0, a_reg[W-1:1]};
                        b_next     = {1'b0, b_reg[W-1:1]};
                    end
                endcase
                if (bit_reg == CNW'(W - 1)) begin
                    state_next = pfx_eval_pkg::S_WRITE;
                end
            end
            pfx_eval_pkg::S_WRITE: begin
                // two popped, one pushed
                count_next = count_m1;
                state_next = pfx_eval_pkg::S_FINISH;
            end
            pfx_eval_pkg::S_FINISH: begin
                state_next = last_reg ? pfx_eval_pkg::S_EMIT : pfx_eval_pkg::S_IDLE;
            end
            pfx_eval_pkg::S_EMIT: begin
                if (out_free) begin
                    mvalid_next = 1'b1;
                    if (count_reg == '0) begin
                        mvalue_next  = '0;
                        mstatus_next = (err_reg != pfx_eval_pkg::ST_OK) ? err_reg
                                                                        : pfx_eval_pkg::ST_UNDER;
                    end else begin
                        mvalue_next  = rd_data_reg;
                        mstatus_next = err_reg;
                    end
                    count_next = '0;
                    err_next   = pfx_eval_pkg::ST_OK;
                    state_next = pfx_eval_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = pfx_eval_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= pfx_eval_pkg::S_IDLE;
            count_reg  <= '0;
            err_reg    <= pfx_eval_pkg::ST_OK;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            err_reg    <= err_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_reg    <= last_next;
        op_reg      <= op_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        acc_reg     <= acc_next;
        carry_reg   <= carry_next;
        neg_reg     <= neg_next;
        bit_reg     <= bit_next;
        mvalue_reg  <= mvalue_next;
        mstatus_reg <= mstatus_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {6'b0, mstatus_reg, mvalue_reg};

`ifndef ASSERT_OFF
    // stack fill never passes the depth
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // write back only happens with two operands on the stack
    a_write_operands: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pfx_eval_pkg::S_WRITE) |-> (count_reg >= CW'(2)))
        else $error("write back without two operands");

    // emitting a result clears the stack and the error and shows the result
    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pfx_eval_pkg::S_EMIT && out_free) |=>
            (count_reg == '0 && err_reg == pfx_eval_pkg::ST_OK && mvalid_reg))
        else $error("emit did not clear state");

    // a recorded error holds until the expression ends
    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != pfx_eval_pkg::ST_OK && state_reg != pfx_eval_pkg::S_EMIT) |=>
            (err_reg == $past(err_reg)))
        else $error("error code replaced before expression end");
`endif

endmodule

// ----- test/postfix_expression_evaluator_tb.sv -----
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_tb
// Self-checking bench for the streaming postfix evaluator. A queue of
// characters feeds a clocked driver on the slave channel. Every accepted
// character is run through a stack predictor inside the bench, and the
// predicted value and status are checked against the master channel.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH = 16;
    localparam int NUM_CHARS   = 1800;      // characters to queue in all, directed part included
    localparam int DRAIN_WAIT  = 64;        // longer than one full operator
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int LONG_HOLD   = 800;       // receiver hold-off, in cycles
    localparam int MAX_PRINTS  = 50;

    // one queued character; a pause entry holds the sender until all
    // expected results have come back
    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
        logic       pause;
    } char_item_t;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } expr_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;     // [7:0] symbol
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;           // [31:0] value, [33:32] status, [39:34] zero

    // stimulus and expectation stores
    char_item_t   char_queue[$];
    expr_result_t pending_results[$];

    // predictor state: operand stack, fill level and sticky error
    logic [31:0] stack_mem [STACK_DEPTH];
    int          stack_fill;
    logic [1:0]  expr_error = pfx_eval_pkg::ST_OK;

    // bookkeeping
    int          n_chars;           // characters queued
    int          chars_sent;        // characters transferred
    int          results_due;       // results predicted so far
    int          results_checked;   // results taken from the master channel
    int          mismatches;
    int          status_tally [4];
    longint      cycle_count;

    // driver-side working variables
    char_item_t  next_char;
    int          tx_gap;
    int          tx_quiet;
    bit          took_char;

    // receiver-side working variables
    expr_result_t want;
    int          rx_hold;
    int          rx_quiet;
    bit          long_hold_done;

    postfix_expression_evaluator #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic bit is_operator(input logic [7:0] sym);
        return sym == pfx_eval_pkg::CH_PLUS || sym == pfx_eval_pkg::CH_MINUS ||
               sym == pfx_eval_pkg::CH_STAR || sym == pfx_eval_pkg::CH_SLASH;
    endfunction

    // keep only the first error of an expression
    task automatic note_error(input logic [1:0] code);
        if (expr_error == pfx_eval_pkg::ST_OK) begin
            expr_error = code;
        end
    endtask

    task automatic push_word(input logic [31:0] word);
        if (stack_fill >= STACK_DEPTH) begin
            note_error(pfx_eval_pkg::ST_OVER);
        end else begin
            stack_mem[stack_fill] = word;
            stack_fill++;
        end
    endtask

    // Advance the predicted stack by one character; on the last character
    // of an expression queue the expected value and status, then clear.
    task automatic predict_char(input logic [7:0] sym, input logic last);
        logic [31:0]  lhs;
        logic [31:0]  rhs;
        logic [31:0]  res;
        logic [31:0]  mag_l;
        logic [31:0]  mag_r;
        logic [31:0]  quo;
        expr_result_t outcome;
        if (is_operator(sym)) begin
            if (stack_fill < 2) begin
                // too few operands: stack untouched
                note_error(pfx_eval_pkg::ST_UNDER);
            end else begin
                rhs = stack_mem[stack_fill - 1];
                lhs = stack_mem[stack_fill - 2];
                stack_fill -= 2;
                case (sym)
                    pfx_eval_pkg::CH_PLUS:  res = lhs + rhs;
                    pfx_eval_pkg::CH_MINUS: res = lhs - rhs;
                    pfx_eval_pkg::CH_STAR:  res = lhs * rhs;
                    default: begin
                        if (rhs == 32'd0) begin
                            note_error(pfx_eval_pkg::ST_DIVZERO);
                            res = 32'd0;
                        end else begin
                            // divide magnitudes, then fix the sign; the most
                            // negative value over -1 wraps back onto itself
                            mag_l = lhs[31] ? -lhs : lhs;
                            mag_r = rhs[31] ? -rhs : rhs;
                            quo   = mag_l / mag_r;
                            res   = (lhs[31] ^ rhs[31]) ? -quo : quo;
                        end
                    end
                endcase
                push_word(res);
            end
        end else begin
            push_word({24'd0, sym} - {24'd0, pfx_eval_pkg::CH_ZERO});
        end

        if (last) begin
            if (stack_fill == 0) begin
                outcome.value  = 32'd0;
                outcome.status = (expr_error != pfx_eval_pkg::ST_OK) ? expr_error
                                                                     : pfx_eval_pkg::ST_UNDER;
            end else begin
                outcome.value  = stack_mem[stack_fill - 1];
                outcome.status = expr_error;
            end
            pending_results.push_back(outcome);
            status_tally[outcome.status]++;
            stack_fill = 0;
            expr_error = pfx_eval_pkg::ST_OK;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
        mismatches++;
    endtask

    task automatic add_char(input logic [7:0] sym, input logic last);
        char_item_t c;
        c.symbol = sym;
        c.last   = last;
        c.pause  = 1'b0;
        char_queue.push_back(c);
        n_chars++;
    endtask

    task automatic add_pause();
        char_item_t c;
        c = '0;
        c.pause = 1'b1;
        char_queue.push_back(c);
    endtask

    function automatic logic [7:0] rand_operator();
        case ($urandom_range(0, 3))
            0:       return pfx_eval_pkg::CH_PLUS;
            1:       return pfx_eval_pkg::CH_MINUS;
            2:       return pfx_eval_pkg::CH_STAR;
            default: return pfx_eval_pkg::CH_SLASH;
        endcase
    endfunction

    // mostly decimal digits, sometimes any non-operator byte
    function automatic logic [7:0] rand_operand();
        logic [7:0] sym;
        if ($urandom_range(0, 4) != 0) begin
            return pfx_eval_pkg::CH_ZERO + 8'($urandom_range(0, 9));
        end
        do begin
            sym = 8'($urandom_range(0, 255));
        end while (is_operator(sym));
        return sym;
    endfunction

    // Build one postfix expression over the given number of operands.
    // A mangled one gets a stray operator and may be left unreduced.
    task automatic add_expression(input int operands, input bit mangle);
        char_item_t seq[$];
        char_item_t c;
        int         depth;
        int         stray_at;
        int         op_odds;
        depth    = 0;
        stray_at = mangle ? $urandom_range(0, operands - 1) : -1;
        op_odds  = (operands > 8) ? 11 : 2;   // deep ones climb past the top
        c        = '0;
        for (int i = 0; i < operands; i++) begin
            if (i == stray_at) begin
                c.symbol = rand_operator();
                seq.push_back(c);
            end
            c.symbol = rand_operand();
            seq.push_back(c);
            depth++;
            while (depth >= 2 && $urandom_range(0, op_odds) == 0) begin
                c.symbol = rand_operator();
                seq.push_back(c);
                depth--;
            end
        end
        if (!(mangle && $urandom_range(0, 1) == 0)) begin
            while (depth > 1) begin
                c.symbol = rand_operator();
                seq.push_back(c);
                depth--;
            end
        end
        seq[seq.size() - 1].last = 1'b1;
        foreach (seq[i]) begin
            add_char(seq[i].symbol, seq[i].last);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(30, 100);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: present queued characters on the slave channel, predict each
    // one as it transfers, and hold at pause entries until drained.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end else begin
            took_char = s_tvalid && s_tready;
            if (took_char) begin
                predict_char(s_tdata, s_tlast);
                chars_sent++;
                if (s_tlast) begin
                    results_due++;
                end
            end
            if (!s_tvalid || took_char) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (char_queue.size() != 0 && char_queue[0].pause) begin
                    // hold until every predicted result has been taken
                    if (results_due == results_checked) begin
                        void'(char_queue.pop_front());
                    end
                    s_tvalid <= 1'b0;
                end else if (char_queue.size() != 0) begin
                    next_char = char_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_char.symbol;
                    s_tlast  <= next_char.last;
                    if (tx_quiet != 0) begin
                        tx_quiet--;
                        tx_gap = 0;
                    end else begin
                        if ($urandom_range(0, 49) == 0) begin
                            tx_quiet = 60;
                        end
                        tx_gap = pick_gap();
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver back-pressure: random stalls, quiet stretches, and one long
    // hold-off once enough results have passed, so the block fills and
    // drops s_tready while the driver keeps offering characters.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold != 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else if (!long_hold_done && results_checked >= 100) begin
            long_hold_done = 1'b1;
            rx_hold = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else if (rx_quiet != 0) begin
            rx_quiet--;
            m_tready <= 1'b1;
        end else if ($urandom_range(0, 199) == 0) begin
            rx_quiet = 300;
            m_tready <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            rx_hold = pick_gap();
            m_tready <= (rx_hold == 0);
            if (rx_hold != 0) begin
                rx_hold--;
            end
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each result transfer against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_checked <= results_checked + 1;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result: value %0d status %0d",
                                          $signed(m_tdata[31:0]), m_tdata[33:32]));
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[31:0] !== want.value) begin
                    report_mismatch($sformatf("result %0d value: got %0d, want %0d",
                                              results_checked, $signed(m_tdata[31:0]),
                                              $signed(want.value)));
                end
                if (m_tdata[33:32] !== want.status) begin
                    report_mismatch($sformatf("result %0d status: got %0d, want %0d",
                                              results_checked, m_tdata[33:32],
                                              want.status));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int r;
        bit mid_pause_done;
        mid_pause_done = 1'b0;

        // extreme codes: 0 pushes -48, 255 pushes 207
        add_char(8'd0, 1'b0);
        add_char(8'd255, 1'b0);
        add_char(pfx_eval_pkg::CH_PLUS, 1'b1);
        // lone operator: underflow with an empty stack
        add_char(pfx_eval_pkg::CH_SLASH, 1'b1);
        // subtraction order: left minus right
        add_char(pfx_eval_pkg::CH_ZERO + 8'd7, 1'b0);
        add_char(pfx_eval_pkg::CH_ZERO + 8'd3, 1'b0);
        add_char(pfx_eval_pkg::CH_MINUS, 1'b1);
        // divide by zero leaves 0 on the stack
        add_char(pfx_eval_pkg::CH_ZERO + 8'd9, 1'b0);
        add_char(pfx_eval_pkg::CH_ZERO, 1'b0);
        add_char(pfx_eval_pkg::CH_SLASH, 1'b1);
        // build the most negative value (128^4 * 8) and divide by -1
        add_char(pfx_eval_pkg::CH_ZERO + 8'd128, 1'b0);
        add_char(pfx_eval_pkg::CH_ZERO + 8'd128, 1'b0);
        add_char(pfx_eval_pkg::CH_STAR, 1'b0);
        add_char(pfx_eval_pkg::CH_ZERO + 8'd128, 1'b0);
        add_char(pfx_eval_pkg::CH_STAR, 1'b0);
        add_char(pfx_eval_pkg::CH_ZERO + 8'd128, 1'b0);
        add_char(pfx_eval_pkg::CH_STAR, 1'b0);
        add_char(pfx_eval_pkg::CH_ZERO + 8'd8, 1'b0);
        add_char(pfx_eval_pkg::CH_STAR, 1'b0);
        add_char(pfx_eval_pkg::CH_ZERO, 1'b0);
        add_char(pfx_eval_pkg::CH_ZERO + 8'd1, 1'b0);
        add_char(pfx_eval_pkg::CH_MINUS, 1'b0);
        add_char(pfx_eval_pkg::CH_SLASH, 1'b1);
        // sticky error: underflow first, then divide by zero is not recorded
        add_char(pfx_eval_pkg::CH_PLUS, 1'b0);
        add_char(pfx_eval_pkg::CH_ZERO + 8'd5, 1'b0);
        add_char(pfx_eval_pkg::CH_ZERO, 1'b0);
        add_char(pfx_eval_pkg::CH_SLASH, 1'b1);
        add_pause();

        // random part: mostly well-formed expressions, some mangled, some noise
        while (n_chars < NUM_CHARS) begin
            if (!mid_pause_done && n_chars >= NUM_CHARS / 2) begin
                add_pause();
                mid_pause_done = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 70) begin
                add_expression(($urandom_range(0, 11) == 0) ? $urandom_range(17, 22)
                                                            : $urandom_range(1, 6), 1'b0);
            end else if (r < 85) begin
                add_expression($urandom_range(1, 8), 1'b1);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    add_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                end
            end
        end
        // close whatever expression the noise left open
        add_char(pfx_eval_pkg::CH_ZERO + 8'd1, 1'b1);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (char_queue.size() != 0 || s_tvalid) @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Run covered %0d characters and %0d checked expression results.",
                 chars_sent, results_checked);
        $display("Status mix: ok %0d, underflow %0d, divide by zero %0d, overflow %0d.",
                 status_tally[pfx_eval_pkg::ST_OK], status_tally[pfx_eval_pkg::ST_UNDER],
                 status_tally[pfx_eval_pkg::ST_DIVZERO], status_tally[pfx_eval_pkg::ST_OVER]);
        if (mismatches == 0) begin
            $display("postfix_expression_evaluator: match");
        end else begin
            $display("postfix_expression_evaluator: mismatch");
        end
        $finish;
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("Timed out after %0d cycles, %0d results outstanding.",
                 cycle_count, pending_results.size());
        $display("postfix_expression_evaluator: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/pfx_eval_pkg.sv
hdl/postfix_expression_evaluator.sv
test/postfix_expression_evaluator_tb.sv
